/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers, compiled out under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// consequence that must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, trig, cons, msg)

`endif

`endif

/* rtl/core/hth_pkg.sv */
// ----------------------------------------------------------------------------
// hth_pkg
// types and constants of the 3x3 hysteresis threshold unit
// ----------------------------------------------------------------------------
package hth_pkg;

   localparam int PIXEL_W     = 8;
   localparam int THRESH_W    = 9;
   localparam int SIZE_W      = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STRONG = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEAK   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd3;

   // register reset values
   localparam logic [THRESH_W-1:0] STRONG_RST       = 9'd64;
   localparam logic [THRESH_W-1:0] WEAK_RST         = 9'd128;
   localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST  = 11'd640;
   localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST = 11'd480;

   // transaction kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   localparam logic [PIXEL_W-1:0] MARK_ON  = 8'hFF;
   localparam logic [PIXEL_W-1:0] MARK_OFF = 8'h00;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic               req_type;
      logic [PIXEL_W-1:0] pixel;
   } hth_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] mark;
      logic               row_end;
      logic               frame_end;
   } hth_rsp_type;

   // which window borders lie inside the frame
   typedef struct packed {
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
   } hth_nbr_type;

   typedef struct packed {
      logic        emit;
      logic        row_end;
      logic        frame_end;
      hth_nbr_type nbr;
   } hth_ctl_type;

endpackage

/* rtl/core/hth_ram.sv */
// ----------------------------------------------------------------------------
// hth_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the contents before a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/hth_window.sv */
// ----------------------------------------------------------------------------
// hth_window
// 3x3 pixel window and hysteresis decision for its centre
// ----------------------------------------------------------------------------
module hth_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic [7:0]                    up_pix,
   input  logic [7:0]                    mid_pix,
   input  logic [7:0]                    low_pix,
   input  hth_pkg::hth_nbr_type          nbr,
   input  logic [hth_pkg::THRESH_W-1:0]  strong_thresh,
   input  logic [hth_pkg::THRESH_W-1:0]  weak_thresh,
   output logic [hth_pkg::PIXEL_W-1:0]   mark
);
   import hth_pkg::*;

   logic [PIXEL_W-1:0] win_ff [3][3];
   logic [PIXEL_W-1:0] col_in [3];
   logic [PIXEL_W-1:0] view   [3][3];
   logic [8:0]         hit;
   logic               centre_strong;
   logic               centre_weak;

   assign col_in[0] = up_pix;
   assign col_in[1] = mid_pix;
   assign col_in[2] = low_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (shift_en) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
            win_ff[r][2] <= col_in[r];
         end
      end
   end

   // window as it stands after this shift
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         view[r][0] = win_ff[r][1];
         view[r][1] = win_ff[r][2];
         view[r][2] = col_in[r];
      end
   end

   // strong pixels among in-frame window positions, centre included
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            hit[r*3+c] = ({1'b0, view[r][c]} < strong_thresh)
                         && (r != 0 || nbr.top_ok)  && (r != 2 || nbr.bot_ok)
                         && (c != 0 || nbr.left_ok) && (c != 2 || nbr.right_ok);
         end
      end
   end

   assign centre_strong = {1'b0, view[1][1]} < strong_thresh;
   assign centre_weak   = {1'b0, view[1][1]} < weak_thresh;

   assign mark = (centre_strong || (centre_weak && (|hit))) ? MARK_ON : MARK_OFF;

endmodule

/* rtl/core/hth_fifo.sv */
// ----------------------------------------------------------------------------
// hth_fifo
// small result queue between the window stage and the result port
// ----------------------------------------------------------------------------
module hth_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  hth_pkg::hth_rsp_type              push_data,
   input  logic                              pop,
   output logic                              out_valid,
   output hth_pkg::hth_rsp_type              out_data,
   output logic [hth_pkg::FIFO_CNT_W-1:0]    count
);
   import hth_pkg::*;

   hth_rsp_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* rtl/core/hysteresis_threshold_3x3_unit.sv */
// ----------------------------------------------------------------------------
// hysteresis_threshold_3x3_unit
// results: each passes the window stage register and the result queue before it
//   is offered; pixel (r, c) is completed by the transaction frame_width + 1 later
// throughput: one transaction per cycle while the queue has room, set by the single
//   write and read port of each line store; a one-row frame adds an internal step
// reset: synchronous, registers to their reset values, counters and queue
//   cleared; line stores keep their contents, no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hysteresis_threshold_3x3_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hth_pkg::hth_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hth_pkg::hth_rsp_type                rsp_data,
   input  logic                                csr_write_en,
   input  logic [hth_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hth_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import hth_pkg::*;

   // column index, latched width, row counter (runs to height + 1), height
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 2);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   localparam logic [WW-1:0] CUR_W_RST =
      WW'((int'(FRAME_WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH : int'(FRAME_WIDTH_RST));
   localparam logic [HW-1:0] CUR_H_RST =
      HW'((int'(FRAME_HEIGHT_RST) > MAX_HEIGHT) ? MAX_HEIGHT : int'(FRAME_HEIGHT_RST));

   // configuration registers
   logic [THRESH_W-1:0] strong_ff;
   logic [THRESH_W-1:0] weak_ff;
   logic [SIZE_W-1:0]   width_ff;
   logic [SIZE_W-1:0]   height_ff;

   // frame position and latched frame size
   logic [CW-1:0] in_col_ff;
   logic [CW-1:0] in_col_in;
   logic [RW-1:0] in_row_ff;
   logic [RW-1:0] in_row_in;
   logic [WW-1:0] cur_w_ff;
   logic [HW-1:0] cur_h_ff;

   // window stage
   logic              s1_valid_ff;
   hth_ctl_type       s1_ctl_ff;
   logic [7:0]        s1_px_ff;
   logic [CW-1:0]     s1_col_ff;
   logic              byp_ff;
   logic [7:0]        byp_data_ff;

   logic [WW-1:0] w_clamp;
   logic [HW-1:0] h_clamp;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [RW-1:0] h_ext;
   logic [RW-1:0] h_plus1;
   logic [WW-1:0] col_inc;

   logic                  is_pixel;
   logic                  is_flush;
   logic                  frame_start;
   logic                  gap_pending;
   logic                  gap_go;
   logic                  room;
   logic                  req_fire;
   logic                  adv_item;
   logic                  do_adv;
   logic [7:0]            px_eff;
   logic                  col_zero;
   hth_ctl_type           ctl;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [FIFO_CNT_W-1:0] occ;

   logic [7:0]  mid_rd;
   logic [7:0]  up_rd;
   logic [7:0]  up_col;
   logic [7:0]  mark;
   hth_rsp_type push_data;

   // ------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         strong_ff <= STRONG_RST;
         weak_ff   <= WEAK_RST;
         width_ff  <= FRAME_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_STRONG: strong_ff <= csr_wdata[THRESH_W-1:0];
            CSR_WEAK:   weak_ff   <= csr_wdata[THRESH_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame size clamped to 1 .. max
   always_comb begin
      if (width_ff == '0) begin
         w_clamp = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_clamp = WW'(MAX_WIDTH);
      end else begin
         w_clamp = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_clamp = HW'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_clamp = HW'(MAX_HEIGHT);
      end else begin
         h_clamp = HW'(height_ff);
      end
   end

   // ------------------------------------------------------------------
   // flow control
   // ------------------------------------------------------------------
   // every transaction in the window stage may still need a queue slot
   assign occ  = fifo_count + FIFO_CNT_W'(s1_valid_ff);
   assign room = occ < FIFO_CNT_W'(FIFO_DEPTH);

   // a one-row frame leaves an empty slot at the start of its drain,
   // stepped over by an internal advance before the first flush is taken
   assign gap_pending = (in_row_ff == RW'(1)) && (in_col_ff == '0)
                        && (cur_h_ff == HW'(1));
   assign gap_go      = gap_pending && room;
   assign req_ready   = room && !gap_pending;
   assign req_fire    = req_valid && req_ready;

   assign is_pixel    = req_data.req_type == REQ_PIXEL;
   assign is_flush    = req_data.req_type == REQ_FLUSH;
   assign frame_start = (in_row_ff == '0) && (in_col_ff == '0);

   // frame size is taken with the first pixel of a frame
   assign w_eff   = (req_fire && is_pixel && frame_start) ? w_clamp : cur_w_ff;
   assign h_eff   = (req_fire && is_pixel && frame_start) ? h_clamp : cur_h_ff;
   assign h_ext   = RW'(h_eff);
   assign h_plus1 = h_ext + RW'(1);

   // pixels while the frame still expects them, flushes once it is complete
   assign adv_item = is_pixel ? (in_row_ff < h_ext) : (in_row_ff >= h_ext);
   assign do_adv   = gap_go || (req_fire && adv_item);
   assign px_eff   = (gap_go || is_flush) ? 8'd0 : req_data.pixel;

   // ------------------------------------------------------------------
   // position of the delayed result and its frame borders
   // ------------------------------------------------------------------
   // at column 0 the result is the last pixel two rows up, else the
   // pixel one row up and one column left
   assign col_zero = in_col_ff == '0;

   always_comb begin
      ctl.emit      = (in_row_ff >= RW'(2)) || ((in_row_ff == RW'(1)) && !col_zero);
      ctl.row_end   = col_zero;
      ctl.frame_end = col_zero && (in_row_ff == h_plus1);
      if (col_zero) begin
         ctl.nbr.top_ok   = in_row_ff >= RW'(3);
         ctl.nbr.bot_ok   = in_row_ff != h_plus1;
         ctl.nbr.left_ok  = w_eff != WW'(1);
         ctl.nbr.right_ok = 1'b0;
      end else begin
         ctl.nbr.top_ok   = in_row_ff >= RW'(2);
         ctl.nbr.bot_ok   = in_row_ff != h_ext;
         ctl.nbr.left_ok  = in_col_ff >= CW'(2);
         ctl.nbr.right_ok = 1'b1;
      end
   end

   // next input position, back to the origin after the frame's last result
   assign col_inc = WW'(in_col_ff) + WW'(1);

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (do_adv) begin
         if (ctl.emit && ctl.frame_end) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if (col_inc >= w_eff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = col_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         cur_w_ff  <= CUR_W_RST;
         cur_h_ff  <= CUR_H_RST;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         if (req_fire && is_pixel && frame_start) begin
            cur_w_ff <= w_clamp;
            cur_h_ff <= h_clamp;
         end
      end
   end

   // ------------------------------------------------------------------
   // line stores
   // ------------------------------------------------------------------
   // middle row: new pixel written where the old one is read
   hth_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_mid_ram (
      .clock   (clock),
      .wr_en   (do_adv),
      .wr_addr (in_col_ff),
      .wr_data (px_eff),
      .rd_addr (in_col_ff),
      .rd_data (mid_rd)
   );

   // upper row: takes the displaced middle pixel in the cycle after
   hth_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_up_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_addr (in_col_ff),
      .rd_data (up_rd)
   );

   // a read of the column being written this cycle sees the new value
   always_ff @(posedge clock) begin
      byp_ff      <= s1_valid_ff && (s1_col_ff == in_col_ff);
      byp_data_ff <= mid_rd;
   end

   assign up_col = byp_ff ? byp_data_ff : up_rd;

   // ------------------------------------------------------------------
   // window stage
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= do_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (do_adv) begin
         s1_ctl_ff <= ctl;
         s1_px_ff  <= px_eff;
         s1_col_ff <= in_col_ff;
      end
   end

   hth_window u_window (
      .clock         (clock),
      .reset         (reset),
      .shift_en      (s1_valid_ff),
      .up_pix        (up_col),
      .mid_pix       (mid_rd),
      .low_pix       (s1_px_ff),
      .nbr           (s1_ctl_ff.nbr),
      .strong_thresh (strong_ff),
      .weak_thresh   (weak_ff),
      .mark          (mark)
   );

   // ------------------------------------------------------------------
   // result queue
   // ------------------------------------------------------------------
   always_comb begin
      push_data.mark      = mark;
      push_data.row_end   = s1_ctl_ff.row_end;
      push_data.frame_end = s1_ctl_ff.frame_end;
   end

   hth_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff && s1_ctl_ff.emit),
      .push_data (push_data),
      .pop       (rsp_valid && rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // queue plus window stage never hold more than the queue can take
   `ASSERT_ALWAYS(a_queue_bound, clock, reset, occ <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overrun")

   // the internal step over the empty slot produces no result
   `ASSERT_NEXT(a_gap_silent, clock, reset, gap_go, !(s1_valid_ff && s1_ctl_ff.emit), "gap step emitted")

   // the row counter never runs past the drain rows of the frame
   `ASSERT_ALWAYS(a_row_bound, clock, reset, in_row_ff <= RW'(cur_h_ff) + RW'(1), "row counter overflow")

endmodule
